FILE: hw/rtl/fcull_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared types and constants for the frustum cull pipeline.
// ----------------------------------------------------------------------------
package fcull_pkg;

    // planes held in configuration
    localparam int PLANE_COUNT = 6;
    localparam int PLANE_W     = 64;

    // field widths
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int FUNC_W   = 2;
    localparam int PROD_W   = 32;
    localparam int DIST_W   = 34;
    localparam int FRAC_SH  = 14;

    // test kinds; the unused code runs as a point test
    typedef enum logic [FUNC_W-1:0] {
        FUNC_POINT  = 2'd0,
        FUNC_SPHERE = 2'd1,
        FUNC_BOX    = 2'd2
    } func_t;

    // one request travelling down the chain, with its running verdict
    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic signed [COORD_W-1:0]  min_x;
        logic signed [COORD_W-1:0]  min_y;
        logic signed [COORD_W-1:0]  min_z;
        logic signed [COORD_W-1:0]  max_x;
        logic signed [COORD_W-1:0]  max_y;
        logic signed [COORD_W-1:0]  max_z;
        logic [RADIUS_W-1:0]        radius;
        logic                       in_frustum;
    } item_t;

endpackage

FILE: hw/rtl/fcull_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_in_if
// Request channel: test kind and bounds of one object.
// ----------------------------------------------------------------------------
interface fcull_in_if
    import fcull_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic signed [COORD_W-1:0]  min_x;
    logic signed [COORD_W-1:0]  min_y;
    logic signed [COORD_W-1:0]  min_z;
    logic signed [COORD_W-1:0]  max_x;
    logic signed [COORD_W-1:0]  max_y;
    logic signed [COORD_W-1:0]  max_z;
    logic [RADIUS_W-1:0]        radius;

    modport source (
        output valid, func, min_x, min_y, min_z, max_x, max_y, max_z, radius,
        input  ready
    );

    modport sink (
        input  valid, func, min_x, min_y, min_z, max_x, max_y, max_z, radius,
        output ready
    );
endinterface

FILE: hw/rtl/fcull_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_out_if
// Result channel: one inside flag per request.
// ----------------------------------------------------------------------------
interface fcull_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );

    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

FILE: hw/rtl/fcull_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_cell
// One plane test: products in the first stage, sum and compare in the second.
// ----------------------------------------------------------------------------
module fcull_cell
    import fcull_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [PLANE_W-1:0] plane,
    input  logic               up_valid,
    output logic               up_ready,
    input  item_t              up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output item_t              dn_item
);

    logic                      valid_a_reg;
    item_t                     item_a_reg;
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;
    logic signed [PROD_W-1:0]  pz_reg;
    logic                      valid_b_reg;
    item_t                     item_b_reg;

    logic                      take_a;
    logic                      take_b;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
    logic signed [PROD_W-1:0]  px_next;
    logic signed [PROD_W-1:0]  py_next;
    logic signed [PROD_W-1:0]  pz_next;
    logic signed [DIST_W-1:0]  dist_sum;
    logic signed [DIST_W-1:0]  limit;
    logic                      reject;
    item_t                     item_b_next;

    // plane fields
    assign nx = plane[15:0];
    assign ny = plane[31:16];
    assign nz = plane[47:32];
    assign d  = plane[63:48];

    // stage advance, a stage moves when it is empty or its successor moves
    assign take_b   = !valid_b_reg || dn_ready;
    assign take_a   = !valid_a_reg || take_b;
    assign up_ready = take_a;

    // vertex choice: box takes the positive vertex, others the center
    always_comb
    begin
        vx = up_item.min_x;
        vy = up_item.min_y;
        vz = up_item.min_z;
        if (up_item.func == FUNC_BOX)
        begin
            vx = nx[COORD_W-1] ? up_item.min_x : up_item.max_x;
            vy = ny[COORD_W-1] ? up_item.min_y : up_item.max_y;
            vz = nz[COORD_W-1] ? up_item.min_z : up_item.max_z;
        end
    end

    // per-axis products
    assign px_next = PROD_W'(nx) * PROD_W'(vx);
    assign py_next = PROD_W'(ny) * PROD_W'(vy);
    assign pz_next = PROD_W'(nz) * PROD_W'(vz);

    // distance and rejection threshold at 14 fraction bits
    always_comb
    begin
        dist_sum = DIST_W'(px_reg) + DIST_W'(py_reg) + DIST_W'(pz_reg)
                 + (DIST_W'(d) <<< FRAC_SH);
        limit = '0;
        if (item_a_reg.func == FUNC_SPHERE)
        begin
            limit = -$signed({5'b0, item_a_reg.radius, {FRAC_SH{1'b0}}});
        end
        reject = dist_sum < limit;
        item_b_next            = item_a_reg;
        item_b_next.in_frustum = item_a_reg.in_frustum && !reject;
    end

    // stage registers, control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (take_a)
            begin
                valid_a_reg <= up_valid;
            end
            if (take_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    // stage registers, payload
    always_ff @(posedge clk)
    begin
        if (take_a)
        begin
            item_a_reg <= up_item;
            px_reg     <= px_next;
            py_reg     <= py_next;
            pz_reg     <= pz_next;
        end
        if (take_b)
        begin
            item_b_reg <= item_b_next;
        end
    end

    assign dn_valid = valid_b_reg;
    assign dn_item  = item_b_reg;

endmodule

FILE: hw/rtl/frustum_cull_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_test_top
// Point, sphere and box test against six frustum planes, one cell per plane.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  item      in    valid/ready    func, min_xyz, max_xyz, radius
//  result    out   valid/ready    inside_res
//  cfg       in    cfg_we         cfg_index, cfg_data (one plane per write)
//
//  one request per cycle sustained while the result side is ready
//  each cell registers its three products, then sums and compares
//  the last cell register holds the result; stages fill bubbles on a stall
//  reset clears valid flags and all planes to zero (everything inside)
// ----------------------------------------------------------------------------
module frustum_cull_test_top
    import fcull_pkg::*;
#(
    parameter int NUM_PLANES = PLANE_COUNT,
    parameter int IDX_W      = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    fcull_in_if.sink           item,
    fcull_out_if.source        result,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [PLANE_W-1:0] cfg_data
);

    logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_reg;
    logic [NUM_PLANES:0]                link_valid;
    logic [NUM_PLANES:0]                link_ready;
    item_t                              link_item [NUM_PLANES+1];

    // plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (cfg_we && (32'(cfg_index) < NUM_PLANES))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    // chain head
    assign link_valid[0]           = item.valid;
    assign item.ready              = link_ready[0];
    assign link_item[0].func       = item.func;
    assign link_item[0].min_x      = item.min_x;
    assign link_item[0].min_y      = item.min_y;
    assign link_item[0].min_z      = item.min_z;
    assign link_item[0].max_x      = item.max_x;
    assign link_item[0].max_y      = item.max_y;
    assign link_item[0].max_z      = item.max_z;
    assign link_item[0].radius     = item.radius;
    assign link_item[0].in_frustum = 1'b1;

    // row of plane cells
    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_cell
        fcull_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .plane    (plane_reg[i]),
            .up_valid (link_valid[i]),
            .up_ready (link_ready[i]),
            .up_item  (link_item[i]),
            .dn_valid (link_valid[i+1]),
            .dn_ready (link_ready[i+1]),
            .dn_item  (link_item[i+1])
        );
    end

    // chain tail
    assign result.valid           = link_valid[NUM_PLANES];
    assign link_ready[NUM_PLANES] = result.ready;
    assign result.inside_res      = link_item[NUM_PLANES].in_frustum;

    // input stalls only when the whole row is full behind a held result
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (result.valid && !result.ready && (&link_valid[NUM_PLANES:1])))
        else $error("input stalled with room in the chain");

    // a write beyond the plane list leaves the planes alone
    a_cfg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (32'(cfg_index) >= NUM_PLANES)) |=> $stable(plane_reg))
        else $error("out of range write changed a plane");

    // a held result stays valid and unchanged until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> (result.valid && $stable(result.inside_res)))
        else $error("held result dropped or changed");

endmodule
